### design/pde_pkg.sv
// ----------------------------------------------------------------------------
// pde_pkg
// Shared widths, register indexes, constants, lane payload type and the
// falling factorial function of the polynomial derivative evaluator.
// ----------------------------------------------------------------------------
package pde_pkg;

  localparam int DEF_MAX_ORDER = 5;

  // field widths
  localparam int TIME_W     = 32;
  localparam int DERIV_W    = 3;
  localparam int ORDER_W    = 3;
  localparam int COEF_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int RES_W      = 48;
  localparam int FRAC_W     = 16;

  // datapath widths
  localparam int FALL_W  = 10;                 // 6! = 720 fits
  localparam int PROD_W  = COEF_W + FALL_W;    // coefficient times factorial
  localparam int MAG_W   = 60;                 // term magnitude, up to 2^59
  localparam int HI_W    = MAG_W - 32;         // upper slice of the magnitude
  localparam int HIP_W   = HI_W + TIME_W;      // upper partial product
  localparam int LOP_W   = 32 + TIME_W;        // lower partial product
  localparam int HI_KEEP = MAG_W - FRAC_W;     // upper product bits after shift
  localparam int ACC_W   = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLY_ORDER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE  = CFG_IDX_W'(1);

  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(5);

  // arithmetic constants
  localparam logic [MAG_W-1:0]  TERM_CAP = MAG_W'(1) << 59;
  localparam logic [HIP_W-1:0]  HI_LIMIT = HIP_W'(TERM_CAP >> FRAC_W);
  localparam logic [TIME_W-1:0] ONE_Q16  = TIME_W'(1) << FRAC_W;
  localparam logic [RES_W-1:0]  RES_MAX  = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0]  RES_MIN  = {1'b1, {(RES_W-1){1'b0}}};

  typedef logic [MAG_W-1:0] mag_t;

  // one term on its way through the multiply chain
  typedef struct packed {
    mag_t               mag;
    logic               neg;
    logic [DERIV_W-1:0] expo;
  } lane_t;

  // power * (power-1) * ... over deriv factors, deriv <= power assumed
  function automatic logic [FALL_W-1:0] fall_fact(input logic [ORDER_W-1:0] power,
                                                  input logic [DERIV_W-1:0] deriv);
    logic [FALL_W-1:0]  f;
    logic [ORDER_W-1:0] fac;
    f   = FALL_W'(1);
    fac = '0;
    for (int k = 0; k < (2**DERIV_W) - 1; k++) begin
      if (DERIV_W'(k) < deriv) begin
        fac = power - ORDER_W'(k);
        f   = FALL_W'(f * fac);
      end
    end
    return f;
  endfunction

endpackage

### design/pde_in_if.sv
// ----------------------------------------------------------------------------
// pde_in_if
// Input channel: evaluation time and derivative level.
// ----------------------------------------------------------------------------
interface pde_in_if;
  import pde_pkg::*;

  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   time_point;
  logic [DERIV_W-1:0]  deriv_level;

  modport source (output valid, time_point, deriv_level, input ready);
  modport sink   (input valid, time_point, deriv_level, output ready);
endinterface

### design/pde_out_if.sv
// ----------------------------------------------------------------------------
// pde_out_if
// Result channel: saturated derivative value and clip flag.
// ----------------------------------------------------------------------------
interface pde_out_if;
  import pde_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  logic                    saturated;

  modport source (output valid, result_value, saturated, input ready);
  modport sink   (input valid, result_value, saturated, output ready);
endinterface

### design/pde_cfg_if.sv
// ----------------------------------------------------------------------------
// pde_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pde_cfg_if;
  import pde_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

### design/pde_cfg_regs.sv
// ----------------------------------------------------------------------------
// pde_cfg_regs
// Polynomial order and coefficient registers, written over the config channel.
// ----------------------------------------------------------------------------
module pde_cfg_regs #(
  parameter int MAX_ORDER = pde_pkg::DEF_MAX_ORDER
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  pde_cfg_if.sink                                  cfg_ch,
  output logic [pde_pkg::ORDER_W-1:0]              order,
  output logic [MAX_ORDER:0][pde_pkg::COEF_W-1:0]  coef
);
  import pde_pkg::*;

  logic [ORDER_W-1:0]              poly_order_r;
  logic [MAX_ORDER:0][COEF_W-1:0]  coef_r;

  // writes are always taken
  assign cfg_ch.ready = 1'b1;

  // register file, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_order_r <= ORDER_RESET;
      coef_r       <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.reg_index == CFG_POLY_ORDER) begin
        poly_order_r <= cfg_ch.wr_data[ORDER_W-1:0];
      end
      for (int i = 0; i <= MAX_ORDER; i++) begin
        if (cfg_ch.reg_index == CFG_COEF_BASE + CFG_IDX_W'(i)) begin
          coef_r[i] <= cfg_ch.wr_data[COEF_W-1:0];
        end
      end
    end
  end

  // order limited to what the lanes support
  assign order = (poly_order_r > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : poly_order_r;
  assign coef  = coef_r;

endmodule

### design/pde_term_prep.sv
// ----------------------------------------------------------------------------
// pde_term_prep
// First stage: coefficient magnitude times falling factorial, remaining
// exponent and sign for every lane.
// ----------------------------------------------------------------------------
module pde_term_prep #(
  parameter int MAX_ORDER = pde_pkg::DEF_MAX_ORDER
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  pde_in_if.sink                                   in_ch,
  input  logic [pde_pkg::ORDER_W-1:0]              order,
  input  logic [MAX_ORDER:0][pde_pkg::COEF_W-1:0]  coef,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [pde_pkg::TIME_W-1:0]               out_t,
  output pde_pkg::lane_t [MAX_ORDER:0]             out_lanes
);
  import pde_pkg::*;

  logic                    valid_r;
  logic [TIME_W-1:0]       t_r;
  lane_t [MAX_ORDER:0]     lane_r;
  lane_t [MAX_ORDER:0]     lane_nxt;

  // per lane term setup; the scaled magnitude stays below 2^42, no clamp needed
  always_comb begin
    logic [ORDER_W-1:0] power;
    logic               used;
    logic [COEF_W-1:0]  abs_c;
    logic [PROD_W-1:0]  prod;
    for (int i = 0; i <= MAX_ORDER; i++) begin
      power = order - ORDER_W'(i);
      used  = (ORDER_W'(i) <= order) && (in_ch.deriv_level <= power);
      abs_c = coef[i][COEF_W-1] ? (~coef[i] + 1'b1) : coef[i];
      prod  = abs_c * fall_fact(power, in_ch.deriv_level);
      lane_nxt[i].mag  = used ? MAG_W'(prod) : '0;
      lane_nxt[i].neg  = coef[i][COEF_W-1];
      lane_nxt[i].expo = used ? (power - in_ch.deriv_level) : '0;
    end
  end

  assign in_ch.ready = !valid_r || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      t_r    <= in_ch.time_point;
      lane_r <= lane_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_t     = t_r;
  assign out_lanes = lane_r;

endmodule

### design/pde_mul_step.sv
// ----------------------------------------------------------------------------
// pde_mul_step
// One Q16.16 multiply by time for every lane, in two stages: partial
// products, then shift, add and clamp. Lanes whose exponent is used up
// multiply by one.
// ----------------------------------------------------------------------------
module pde_mul_step #(
  parameter int MAX_ORDER = pde_pkg::DEF_MAX_ORDER,
  parameter int STEP      = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pde_pkg::TIME_W-1:0]      in_t,
  input  pde_pkg::lane_t [MAX_ORDER:0]    in_lanes,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pde_pkg::TIME_W-1:0]      out_t,
  output pde_pkg::lane_t [MAX_ORDER:0]    out_lanes
);
  import pde_pkg::*;

  localparam logic [DERIV_W-1:0] STEP_IDX = DERIV_W'(STEP);

  // partial product stage
  logic                              va_r;
  logic [TIME_W-1:0]                 ta_r;
  logic [MAX_ORDER:0][HIP_W-1:0]     hi_r;
  logic [MAX_ORDER:0][LOP_W-1:0]     lo_r;
  logic [MAX_ORDER:0]                neg_a_r;
  logic [MAX_ORDER:0][DERIV_W-1:0]   expo_a_r;
  logic [MAX_ORDER:0][HIP_W-1:0]     hi_nxt;
  logic [MAX_ORDER:0][LOP_W-1:0]     lo_nxt;

  // combine stage
  logic                              vb_r;
  logic [TIME_W-1:0]                 tb_r;
  lane_t [MAX_ORDER:0]               lane_b_r;
  lane_t [MAX_ORDER:0]               lane_b_nxt;

  logic                              ready_b;

  assign ready_b  = !vb_r || out_ready;
  assign in_ready = !va_r || ready_b;

  // split the magnitude and multiply both halves
  always_comb begin
    logic [TIME_W-1:0] op_b;
    for (int i = 0; i <= MAX_ORDER; i++) begin
      op_b      = (STEP_IDX < in_lanes[i].expo) ? in_t : ONE_Q16;
      hi_nxt[i] = in_lanes[i].mag[MAG_W-1:32] * op_b;
      lo_nxt[i] = in_lanes[i].mag[31:0] * op_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (in_ready) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ta_r <= in_t;
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
      for (int i = 0; i <= MAX_ORDER; i++) begin
        neg_a_r[i]  <= in_lanes[i].neg;
        expo_a_r[i] <= in_lanes[i].expo;
      end
    end
  end

  // drop 16 fraction bits and clamp to the term cap
  always_comb begin
    logic [MAG_W:0] sum_w;
    for (int i = 0; i <= MAX_ORDER; i++) begin
      sum_w = (MAG_W+1)'({hi_r[i][HI_KEEP-1:0], FRAC_W'(0)}) +
              (MAG_W+1)'(lo_r[i][LOP_W-1:FRAC_W]);
      if (hi_r[i] > HI_LIMIT) begin
        lane_b_nxt[i].mag = TERM_CAP;
      end else if (sum_w > {1'b0, TERM_CAP}) begin
        lane_b_nxt[i].mag = TERM_CAP;
      end else begin
        lane_b_nxt[i].mag = sum_w[MAG_W-1:0];
      end
      lane_b_nxt[i].neg  = neg_a_r[i];
      lane_b_nxt[i].expo = expo_a_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (ready_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && va_r) begin
      tb_r     <= ta_r;
      lane_b_r <= lane_b_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_t     = tb_r;
  assign out_lanes = lane_b_r;

endmodule

### design/pde_sum_sat.sv
// ----------------------------------------------------------------------------
// pde_sum_sat
// Signed sum of all lanes over two stages, then saturation to Q32.16 in
// the output register.
// ----------------------------------------------------------------------------
module pde_sum_sat #(
  parameter int MAX_ORDER = pde_pkg::DEF_MAX_ORDER
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pde_pkg::lane_t [MAX_ORDER:0]    in_lanes,
  pde_out_if.source                       out_ch
);
  import pde_pkg::*;

  localparam int LANES = MAX_ORDER + 1;
  localparam int NP    = (LANES + 1) / 2;

  logic                               vp_r;
  logic [NP-1:0][ACC_W-1:0]           pair_r;
  logic [NP-1:0][ACC_W-1:0]           pair_nxt;
  logic                               vs_r;
  logic [ACC_W-1:0]                   acc_r;
  logic [ACC_W-1:0]                   acc_nxt;
  logic                               vo_r;
  logic [RES_W-1:0]                   res_r;
  logic                               sat_r;
  logic [RES_W-1:0]                   res_nxt;
  logic                               sat_nxt;
  logic                               ready_s;
  logic                               ready_o;

  function automatic logic [ACC_W-1:0] signed_term(input lane_t l);
    logic [ACC_W-1:0] m;
    m = ACC_W'(l.mag);
    return l.neg ? (~m + 1'b1) : m;
  endfunction

  assign ready_o  = !vo_r || out_ch.ready;
  assign ready_s  = !vs_r || ready_o;
  assign in_ready = !vp_r || ready_s;

  // pairwise sums
  always_comb begin
    logic [2*NP-1:0][ACC_W-1:0] terms;
    terms = '0;
    for (int i = 0; i < LANES; i++) begin
      terms[i] = signed_term(in_lanes[i]);
    end
    for (int p = 0; p < NP; p++) begin
      pair_nxt[p] = terms[2*p] + terms[2*p+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (in_ready) begin
      vp_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pair_r <= pair_nxt;
    end
  end

  // final sum of the pairs
  always_comb begin
    acc_nxt = '0;
    for (int p = 0; p < NP; p++) begin
      acc_nxt = acc_nxt + pair_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else if (ready_s) begin
      vs_r <= vp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_s && vp_r) begin
      acc_r <= acc_nxt;
    end
  end

  // clip to signed 48 bits
  always_comb begin
    if ((acc_r[ACC_W-1:RES_W-1] == '0) || (acc_r[ACC_W-1:RES_W-1] == '1)) begin
      res_nxt = acc_r[RES_W-1:0];
      sat_nxt = 1'b0;
    end else if (acc_r[ACC_W-1]) begin
      res_nxt = RES_MIN;
      sat_nxt = 1'b1;
    end else begin
      res_nxt = RES_MAX;
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (ready_o) begin
      vo_r <= vs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && vs_r) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid        = vo_r;
  assign out_ch.result_value = res_r;
  assign out_ch.saturated    = sat_r;

endmodule

### design/polynomial_derivative_eval.sv
// ----------------------------------------------------------------------------
// polynomial_derivative_eval
// Evaluates a chosen derivative of a fixed-point polynomial at a given time.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch  writes poly_order (index 0) and coef_0..coef_MAX_ORDER (index 1..).
//           Always ready; write only while no item is in flight.
//   in_ch   takes time_point (unsigned Q16.16) and deriv_level per transfer.
//   out_ch  gives result_value (signed Q32.16, saturated) and saturated,
//           one result per input, in input order.
// The pipeline has one term setup stage, two stages per multiply by time
// (partial products, then shift and clamp) for MAX_ORDER multiplies, two
// sum stages and the output register. Throughput is one transfer per cycle
// while the receiver takes results; every lane has its own multipliers at
// every step.
// Each stage holds its data while the next one is full, so a stalled receiver
// only backs up the pipeline; empty stages still take new transfers.
// Reset clears all stage valid bits and sets poly_order to 5 and all
// coefficients to zero.
// ----------------------------------------------------------------------------
module polynomial_derivative_eval #(
  parameter int MAX_ORDER = pde_pkg::DEF_MAX_ORDER
) (
  input  logic        clk,
  input  logic        rst_n,
  pde_in_if.sink      in_ch,
  pde_out_if.source   out_ch,
  pde_cfg_if.sink     cfg_ch
);
  import pde_pkg::*;

  logic [ORDER_W-1:0]              order;
  logic [MAX_ORDER:0][COEF_W-1:0]  coef;

  // stage chain between term setup, multiply steps and the summer
  logic                    st_valid [MAX_ORDER+1];
  logic                    st_ready [MAX_ORDER+1];
  logic [TIME_W-1:0]       st_t     [MAX_ORDER];
  lane_t [MAX_ORDER:0]     st_lanes [MAX_ORDER+1];

  pde_cfg_regs #(.MAX_ORDER(MAX_ORDER)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .order  (order),
    .coef   (coef)
  );

  pde_term_prep #(.MAX_ORDER(MAX_ORDER)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .order     (order),
    .coef      (coef),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .out_t     (st_t[0]),
    .out_lanes (st_lanes[0])
  );

  // one multiply by time per step
  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_step
    if (k < MAX_ORDER - 1) begin : g_mid
      pde_mul_step #(.MAX_ORDER(MAX_ORDER), .STEP(k)) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid[k]),
        .in_ready  (st_ready[k]),
        .in_t      (st_t[k]),
        .in_lanes  (st_lanes[k]),
        .out_valid (st_valid[k+1]),
        .out_ready (st_ready[k+1]),
        .out_t     (st_t[k+1]),
        .out_lanes (st_lanes[k+1])
      );
    end else begin : g_last
      pde_mul_step #(.MAX_ORDER(MAX_ORDER), .STEP(k)) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid[k]),
        .in_ready  (st_ready[k]),
        .in_t      (st_t[k]),
        .in_lanes  (st_lanes[k]),
        .out_valid (st_valid[k+1]),
        .out_ready (st_ready[k+1]),
        .out_t     (),
        .out_lanes (st_lanes[k+1])
      );
    end
  end

  pde_sum_sat #(.MAX_ORDER(MAX_ORDER)) u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (st_valid[MAX_ORDER]),
    .in_ready (st_ready[MAX_ORDER]),
    .in_lanes (st_lanes[MAX_ORDER]),
    .out_ch   (out_ch)
  );

endmodule

### design/pde_checker.sv
// ----------------------------------------------------------------------------
// pde_checker
// Port-level checks of the evaluator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pde_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pde_pkg::RES_W-1:0]   out_result,
  input logic                        out_sat
);
  import pde_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result) && $stable(out_sat))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // a clipped result sits at one of the range limits
  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sat |-> (out_result == RES_MAX) || (out_result == RES_MIN))
    else $error("saturated result not at a limit");

  // with the output register empty every stage can move, so input is taken
  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind polynomial_derivative_eval pde_checker u_pde_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result_value),
  .out_sat    (out_ch.saturated)
);
